[hw/rtl/camera_basis_from_look_at_assert.svh]
`ifndef CAMERA_BASIS_FROM_LOOK_AT_ASSERT_SVH
`define CAMERA_BASIS_FROM_LOOK_AT_ASSERT_SVH

// checked only out of reset
`define CBLA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// checked at every edge, reset included
`define CBLA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/cbla_pkg.sv]
`default_nettype none

package cbla_pkg;

    localparam int NORM_BITS  = 30;
    localparam int SUM_BITS   = 62;
    localparam int ROOT_BITS  = 31;
    localparam int SQRT_STEPS = 32;
    localparam int SQRT_W     = 64;

    localparam int OUT_W  = 16;
    localparam int SAT_HI = 32767;
    localparam int SAT_LO = -32768;

    typedef struct packed {
        logic [8:0][OUT_W-1:0] comp;
        logic                  degen;
    } t_basis;

endpackage

`default_nettype wire

[hw/rtl/cbla_norm.sv]
`default_nettype none

module cbla_norm import cbla_pkg::*; #(
    parameter int CW   = 33,
    parameter int FRAC = 14,
    parameter int SW   = 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic signed [CW-1:0]   i_c [3],
    input  logic [SW-1:0]          i_side,
    output logic                   o_valid,
    output logic signed [FRAC+1:0] o_q [3],
    output logic                   o_zero,
    output logic [SW-1:0]          o_side
);

    localparam int LW = (CW > NORM_BITS) ? CW : NORM_BITS;
    localparam int SH = $clog2(LW);
    localparam int NW = FRAC + NORM_BITS + 1;
    localparam int QW = FRAC + 1;
    localparam int RW = ROOT_BITS;

    typedef struct packed {
        logic [2:0]    sg;
        logic          zero;
        logic [SW-1:0] side;
    } t_carry;

    // magnitudes and leading-zero alignment
    logic [CW-1:0] abs_c [3];
    logic [LW-1:0] r_sm [SH+1][3];
    t_carry        r_sc [SH+1];
    logic          r_sv [SH+1];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            abs_c[i] = i_c[i][CW-1] ? $unsigned(-i_c[i]) : $unsigned(i_c[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_sv[0] <= 1'b0;
        else if (i_en) r_sv[0] <= i_valid;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) r_sm[0][i] <= LW'(abs_c[i]);
            r_sc[0].sg   <= {i_c[2][CW-1], i_c[1][CW-1], i_c[0][CW-1]};
            r_sc[0].zero <= (abs_c[0] | abs_c[1] | abs_c[2]) == '0;
            r_sc[0].side <= i_side;
        end
    end

    for (genvar k = 0; k < SH; k++) begin : g_align
        localparam int K = 1 << (SH - 1 - k);
        logic [LW-1:0] any;
        logic          hit;
        assign any = r_sm[k][0] | r_sm[k][1] | r_sm[k][2];
        assign hit = any[LW-1 -: K] == '0;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_sv[k+1] <= 1'b0;
            else if (i_en) r_sv[k+1] <= r_sv[k];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int i = 0; i < 3; i++) begin
                    r_sm[k+1][i] <= hit ? (r_sm[k][i] << K) : r_sm[k][i];
                end
                r_sc[k+1] <= r_sc[k];
            end
        end
    end

    // squares
    logic [NORM_BITS-1:0]   r_qm [3];
    logic [2*NORM_BITS-1:0] r_sq [3];
    t_carry                 r_qc;
    logic                   r_qv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_qv <= 1'b0;
        else if (i_en) r_qv <= r_sv[SH];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_qm[i] <= r_sm[SH][i][LW-1 -: NORM_BITS];
                r_sq[i] <= r_sm[SH][i][LW-1 -: NORM_BITS] * r_sm[SH][i][LW-1 -: NORM_BITS];
            end
            r_qc <= r_sc[SH];
        end
    end

    // square root, one result bit per stage
    logic [SQRT_W-1:0]    r_tx [SQRT_STEPS+1];
    logic [SQRT_W-1:0]    r_tr [SQRT_STEPS+1];
    logic [NORM_BITS-1:0] r_tm [SQRT_STEPS+1][3];
    t_carry               r_tc [SQRT_STEPS+1];
    logic                 r_tv [SQRT_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_tv[0] <= 1'b0;
        else if (i_en) r_tv[0] <= r_qv;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tx[0] <= SQRT_W'(SUM_BITS'(r_sq[0]) + SUM_BITS'(r_sq[1]) + SUM_BITS'(r_sq[2]));
            r_tr[0] <= '0;
            for (int i = 0; i < 3; i++) r_tm[0][i] <= r_qm[i];
            r_tc[0] <= r_qc;
        end
    end

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        localparam logic [SQRT_W-1:0] BIT = SQRT_W'(1) << (SUM_BITS - 2 * k);
        logic [SQRT_W-1:0] trial;
        logic              take;
        assign trial = r_tr[k] + BIT;
        assign take  = r_tx[k] >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_tv[k+1] <= 1'b0;
            else if (i_en) r_tv[k+1] <= r_tv[k];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tx[k+1] <= take ? (r_tx[k] - trial) : r_tx[k];
                r_tr[k+1] <= take ? ((r_tr[k] >> 1) + BIT) : (r_tr[k] >> 1);
                for (int i = 0; i < 3; i++) r_tm[k+1][i] <= r_tm[k][i];
                r_tc[k+1] <= r_tc[k];
            end
        end
    end

    // rounded numerator, then one quotient bit per stage
    logic [RW-1:0] root;
    logic [NW-1:0] num [3];
    logic [RW-1:0] r_dr   [QW+1][3];
    logic [QW-1:0] r_dq   [QW+1][3];
    logic [NW-1:0] r_dnum [QW+1][3];
    logic [RW-1:0] r_dn   [QW+1];
    t_carry        r_dc   [QW+1];
    logic          r_dv   [QW+1];

    assign root = r_tr[SQRT_STEPS][RW-1:0];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            num[i] = (NW'(r_tm[SQRT_STEPS][i]) << FRAC) + NW'(root >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_dv[0] <= 1'b0;
        else if (i_en) r_dv[0] <= r_tv[SQRT_STEPS];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_dr[0][i]   <= RW'(num[i] >> QW);
                r_dq[0][i]   <= '0;
                r_dnum[0][i] <= num[i];
            end
            r_dn[0] <= root;
            r_dc[0] <= r_tc[SQRT_STEPS];
        end
    end

    for (genvar j = 0; j < QW; j++) begin : g_div
        logic [RW:0] part [3];
        logic        ge   [3];

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                part[i] = {r_dr[j][i], r_dnum[j][i][QW-1-j]};
                ge[i]   = part[i] >= {1'b0, r_dn[j]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_dv[j+1] <= 1'b0;
            else if (i_en) r_dv[j+1] <= r_dv[j];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int i = 0; i < 3; i++) begin
                    r_dr[j+1][i]   <= ge[i] ? RW'(part[i] - {1'b0, r_dn[j]}) : RW'(part[i]);
                    r_dq[j+1][i]   <= {r_dq[j][i][QW-2:0], ge[i]};
                    r_dnum[j+1][i] <= r_dnum[j][i];
                end
                r_dn[j+1] <= r_dn[j];
                r_dc[j+1] <= r_dc[j];
            end
        end
    end

    // sign restore
    logic signed [FRAC+1:0] r_oq [3];
    t_carry                 r_oc;
    logic                   r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (i_en) r_ov <= r_dv[QW];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_oq[i] <= r_dc[QW].sg[i] ? -$signed({1'b0, r_dq[QW][i]})
                                          : $signed({1'b0, r_dq[QW][i]});
            end
            r_oc <= r_dc[QW];
        end
    end

    assign o_valid = r_ov;
    assign o_q     = r_oq;
    assign o_zero  = r_oc.zero;
    assign o_side  = r_oc.side;

endmodule

`default_nettype wire

[hw/rtl/camera_basis_from_look_at.sv]
// Look-at camera basis. Takes one transfer per cycle while o_stall is low and returns
// the basis u (right), v (upward) and w (back) in signed Q1.OUT_FRAC_BITS, saturated to
// 16 bits, plus a degenerate flag that zeroes the basis when w or u has no length; views
// straight down or straight up the y axis give a fixed basis instead. Two normalizers
// each run a bit-serial pipelined square root and a pipelined divider, one result bit
// per stage; the cross product, rounding and output buffer add stages of their own.
// A two-entry output buffer lets the pipeline keep taking items while a result waits.
`default_nettype none

module camera_basis_from_look_at import cbla_pkg::*; #(
    parameter int OUT_FRAC_BITS = 14
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_eye_x,
    input  logic signed [31:0] i_eye_y,
    input  logic signed [31:0] i_eye_z,
    input  logic signed [31:0] i_target_x,
    input  logic signed [31:0] i_target_y,
    input  logic signed [31:0] i_target_z,
    input  logic signed [31:0] i_up_x,
    input  logic signed [31:0] i_up_y,
    input  logic signed [31:0] i_up_z,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_right_x,
    output logic signed [15:0] o_right_y,
    output logic signed [15:0] o_right_z,
    output logic signed [15:0] o_upward_x,
    output logic signed [15:0] o_upward_y,
    output logic signed [15:0] o_upward_z,
    output logic signed [15:0] o_back_x,
    output logic signed [15:0] o_back_y,
    output logic signed [15:0] o_back_z,
    output logic               o_degenerate
);

    localparam int F   = OUT_FRAC_BITS;
    localparam int UW  = F + 2;
    localparam int PW  = 32 + UW;
    localparam int CW2 = PW + 1;
    localparam int VPW = 2 * UW;
    localparam int VDW = VPW + 1;
    localparam int VW  = F + 7;
    localparam int EW  = (VW > 17) ? VW : 17;
    localparam int SW1 = 3 * 32 + 2;
    localparam int SW2 = 3 * UW + 3;

    logic en;

    // difference and vertical view detection
    logic               r0_v;
    logic signed [32:0] r0_d  [3];
    logic signed [31:0] r0_up [3];
    logic               r0_down, r0_rise;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r0_v <= 1'b0;
        else if (en) r0_v <= i_valid;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_d[0]  <= 33'(i_eye_x) - 33'(i_target_x);
            r0_d[1]  <= 33'(i_eye_y) - 33'(i_target_y);
            r0_d[2]  <= 33'(i_eye_z) - 33'(i_target_z);
            r0_up[0] <= i_up_x;
            r0_up[1] <= i_up_y;
            r0_up[2] <= i_up_z;
            r0_down  <= (i_eye_x == i_target_x) && (i_eye_z == i_target_z) &&
                        (i_eye_y > i_target_y);
            r0_rise  <= (i_eye_x == i_target_x) && (i_eye_z == i_target_z) &&
                        (i_eye_y < i_target_y);
        end
    end

    // w = normalize(eye - target)
    logic              n1_v, n1_zero;
    logic signed [UW-1:0] n1_w [3];
    logic [SW1-1:0]    n1_side;

    cbla_norm #(.CW(33), .FRAC(F), .SW(SW1)) u_norm_w (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r0_v),
        .i_c     (r0_d),
        .i_side  ({r0_up[2], r0_up[1], r0_up[0], r0_down, r0_rise}),
        .o_valid (n1_v),
        .o_q     (n1_w),
        .o_zero  (n1_zero),
        .o_side  (n1_side)
    );

    logic signed [31:0] n1_up [3];
    assign n1_up[0] = n1_side[33:2];
    assign n1_up[1] = n1_side[65:34];
    assign n1_up[2] = n1_side[97:66];

    // up x w
    logic                 r1_v, r1_down, r1_rise, r1_zero;
    logic signed [PW-1:0] r1_p [6];
    logic signed [UW-1:0] r1_w [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else if (en) r1_v <= n1_v;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_p[0] <= PW'(n1_up[1]) * PW'(n1_w[2]);
            r1_p[1] <= PW'(n1_up[2]) * PW'(n1_w[1]);
            r1_p[2] <= PW'(n1_up[2]) * PW'(n1_w[0]);
            r1_p[3] <= PW'(n1_up[0]) * PW'(n1_w[2]);
            r1_p[4] <= PW'(n1_up[0]) * PW'(n1_w[1]);
            r1_p[5] <= PW'(n1_up[1]) * PW'(n1_w[0]);
            r1_w    <= n1_w;
            r1_down <= n1_side[1];
            r1_rise <= n1_side[0];
            r1_zero <= n1_zero;
        end
    end

    logic                  r2_v, r2_down, r2_rise, r2_zero;
    logic signed [CW2-1:0] r2_c [3];
    logic signed [UW-1:0]  r2_w [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else if (en) r2_v <= r1_v;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_c[0] <= CW2'(r1_p[0]) - CW2'(r1_p[1]);
            r2_c[1] <= CW2'(r1_p[2]) - CW2'(r1_p[3]);
            r2_c[2] <= CW2'(r1_p[4]) - CW2'(r1_p[5]);
            r2_w    <= r1_w;
            r2_down <= r1_down;
            r2_rise <= r1_rise;
            r2_zero <= r1_zero;
        end
    end

    // u = normalize(up x w)
    logic                 n2_v, n2_zero;
    logic signed [UW-1:0] n2_u [3];
    logic [SW2-1:0]       n2_side;
    logic signed [UW-1:0] n2_w [3];

    cbla_norm #(.CW(CW2), .FRAC(F), .SW(SW2)) u_norm_u (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r2_v),
        .i_c     (r2_c),
        .i_side  ({r2_w[2], r2_w[1], r2_w[0], r2_down, r2_rise, r2_zero}),
        .o_valid (n2_v),
        .o_q     (n2_u),
        .o_zero  (n2_zero),
        .o_side  (n2_side)
    );

    assign n2_w[0] = n2_side[UW+2:3];
    assign n2_w[1] = n2_side[2*UW+2:UW+3];
    assign n2_w[2] = n2_side[3*UW+2:2*UW+3];

    // v = w x u
    logic                  r3_v, r3_down, r3_rise, r3_degen;
    logic signed [VPW-1:0] r3_p [6];
    logic signed [UW-1:0]  r3_u [3];
    logic signed [UW-1:0]  r3_w [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else if (en) r3_v <= n2_v;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_p[0]  <= VPW'(n2_w[1]) * VPW'(n2_u[2]);
            r3_p[1]  <= VPW'(n2_w[2]) * VPW'(n2_u[1]);
            r3_p[2]  <= VPW'(n2_w[2]) * VPW'(n2_u[0]);
            r3_p[3]  <= VPW'(n2_w[0]) * VPW'(n2_u[2]);
            r3_p[4]  <= VPW'(n2_w[0]) * VPW'(n2_u[1]);
            r3_p[5]  <= VPW'(n2_w[1]) * VPW'(n2_u[0]);
            r3_u     <= n2_u;
            r3_w     <= n2_w;
            r3_down  <= n2_side[2];
            r3_rise  <= n2_side[1];
            r3_degen <= n2_side[0] || n2_zero;
        end
    end

    logic                  r4_v, r4_down, r4_rise, r4_degen;
    logic signed [VDW-1:0] r4_c [3];
    logic signed [UW-1:0]  r4_u [3];
    logic signed [UW-1:0]  r4_w [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else if (en) r4_v <= r3_v;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_c[0]  <= VDW'(r3_p[0]) - VDW'(r3_p[1]);
            r4_c[1]  <= VDW'(r3_p[2]) - VDW'(r3_p[3]);
            r4_c[2]  <= VDW'(r3_p[4]) - VDW'(r3_p[5]);
            r4_u     <= r3_u;
            r4_w     <= r3_w;
            r4_down  <= r3_down;
            r4_rise  <= r3_rise;
            r4_degen <= r3_degen;
        end
    end

    // round half away from zero
    logic [VDW-1:0]       y_mag [3];
    logic [VDW:0]         y_rnd [3];
    logic signed [VW-1:0] y_q   [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            y_mag[i] = r4_c[i][VDW-1] ? $unsigned(-r4_c[i]) : $unsigned(r4_c[i]);
            y_rnd[i] = (VDW+1)'(y_mag[i]) + ((VDW+1)'(1) << (F - 1));
            y_q[i]   = $signed(VW'(y_rnd[i] >> F));
            if (r4_c[i][VDW-1]) y_q[i] = -y_q[i];
        end
    end

    logic                 r5_v, r5_down, r5_rise, r5_degen;
    logic signed [VW-1:0] r5_vv [3];
    logic signed [UW-1:0] r5_u  [3];
    logic signed [UW-1:0] r5_w  [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_v <= 1'b0;
        else if (en) r5_v <= r4_v;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_vv    <= y_q;
            r5_u     <= r4_u;
            r5_w     <= r4_w;
            r5_down  <= r4_down;
            r5_rise  <= r4_rise;
            r5_degen <= r4_degen;
        end
    end

    // fixed views, degenerate zeroing and saturation
    function automatic logic [OUT_W-1:0] sat(input logic signed [VW-1:0] v);
        logic signed [EW-1:0] e;
        e = EW'(v);
        if (e > EW'(SAT_HI)) sat = OUT_W'(SAT_HI);
        else if (e < EW'(SAT_LO)) sat = OUT_W'(SAT_LO);
        else sat = OUT_W'(e);
    endfunction

    logic signed [VW-1:0] one;
    logic signed [VW-1:0] sel [9];
    logic                 degen;
    t_basis               fin;

    assign one   = VW'(1) << F;
    assign degen = !r5_down && !r5_rise && r5_degen;

    always_comb begin
        for (int i = 0; i < 9; i++) sel[i] = '0;
        priority if (r5_down) begin
            sel[2] = one;
            sel[3] = one;
            sel[7] = one;
        end else if (r5_rise) begin
            sel[0] = one;
            sel[5] = one;
            sel[7] = -one;
        end else begin
            if (!degen) begin
                for (int i = 0; i < 3; i++) begin
                    sel[i]     = VW'(r5_u[i]);
                    sel[3 + i] = r5_vv[i];
                    sel[6 + i] = VW'(r5_w[i]);
                end
            end
        end
        for (int i = 0; i < 9; i++) fin.comp[i] = sat(sel[i]);
        fin.degen = degen;
    end

    logic   r6_v;
    t_basis r6_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r6_v <= 1'b0;
        else if (en) r6_v <= r5_v;
    end

    always_ff @(posedge i_clk) begin
        if (en) r6_b <= fin;
    end

    // output buffer
    t_basis     r_buf [2];
    logic [1:0] r_cnt;
    logic       r_wp, r_rp;
    logic       push, pop;
    t_basis     head;

    assign pop  = o_valid && !i_stall;
    assign en   = !r_cnt[1] || !i_stall;
    assign push = en && r6_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
            if (push) r_wp <= !r_wp;
            if (pop) r_rp <= !r_rp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_buf[r_wp] <= r6_b;
    end

    assign head         = r_buf[r_rp];
    assign o_valid      = r_cnt != 2'd0;
    assign o_stall      = !en;
    assign o_right_x    = head.comp[0];
    assign o_right_y    = head.comp[1];
    assign o_right_z    = head.comp[2];
    assign o_upward_x   = head.comp[3];
    assign o_upward_y   = head.comp[4];
    assign o_upward_z   = head.comp[5];
    assign o_back_x     = head.comp[6];
    assign o_back_y     = head.comp[7];
    assign o_back_z     = head.comp[8];
    assign o_degenerate = head.degen;

endmodule

`default_nettype wire

[hw/rtl/cbla_check.sv]
`default_nettype none
`include "camera_basis_from_look_at_assert.svh"

module cbla_check import cbla_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_stall,
    input logic             o_valid,
    input logic             o_stall,
    input logic [OUT_W-1:0] o_right_x,
    input logic [OUT_W-1:0] o_right_y,
    input logic [OUT_W-1:0] o_right_z,
    input logic [OUT_W-1:0] o_upward_x,
    input logic [OUT_W-1:0] o_upward_y,
    input logic [OUT_W-1:0] o_upward_z,
    input logic [OUT_W-1:0] o_back_x,
    input logic [OUT_W-1:0] o_back_y,
    input logic [OUT_W-1:0] o_back_z,
    input logic             o_degenerate
);

    `CBLA_ASSERT(a_valid_held, i_clk, i_rst_n, o_valid && i_stall |=> o_valid, "output valid dropped while stalled")
    `CBLA_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_valid, "output valid after reset")
    `CBLA_ASSERT(a_empty_takes, i_clk, i_rst_n, !o_valid |-> !o_stall, "input stalled with empty output")
    `CBLA_ASSERT(a_degen_zero, i_clk, i_rst_n, o_valid && o_degenerate |-> (o_right_x == '0 && o_right_y == '0 && o_right_z == '0 && o_upward_x == '0 && o_upward_y == '0 && o_upward_z == '0 && o_back_x == '0 && o_back_y == '0 && o_back_z == '0), "degenerate basis not zero")

endmodule

bind camera_basis_from_look_at cbla_check u_check (.*);

`default_nettype wire
